FILE: rtl/octahedral_tangent_pack_top_defines.svh
// Assertion macros for the octahedral tangent packer.
// Used by octahedral_tangent_pack_top; expects clk and rst in scope.
`ifndef OCTAHEDRAL_TANGENT_PACK_TOP_DEFINES_SVH
`define OCTAHEDRAL_TANGENT_PACK_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("otp assertion failed");
`define OTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("otp assertion failed");
`else
`define OTP_ASSERT_NOW(label, ante, cons)
`define OTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/otp_pkg.sv
// Constants and types for the octahedral tangent packer.
// No dependencies; used by otp_divider and octahedral_tangent_pack_top.
package otp_pkg;
  localparam int STEPS       = 1023;
  localparam int COORD_BITS  = 11;
  localparam int PRESENT_BIT = 31;
  localparam int FLIPPED_BIT = 30;
  localparam int IN_WIDTH    = 16;

  // |x|+|y|+|z| needs IN_WIDTH+1 bits; one spare
  localparam int S_W        = IN_WIDTH + 2;
  localparam int Q_W        = $clog2(STEPS + 1);
  localparam int D_W        = S_W + 1;
  localparam int N_W        = S_W + Q_W + 2;
  localparam int CODE_W     = Q_W + 1;
  localparam int DIV_STAGES = (Q_W + 1) / 2;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic zero;
    logic flip;
  } side_t;
endpackage

FILE: rtl/otp_divider.sv
// Pipelined restoring divider, two quotient bits per stage.
// Depends on otp_pkg.
module otp_divider (
  input  logic                    clk,
  input  logic                    en,
  input  logic [otp_pkg::N_W-1:0] num,
  input  logic [otp_pkg::D_W-1:0] den,
  output logic [otp_pkg::Q_W-1:0] quo
);
  logic [otp_pkg::N_W-1:0] rem_q [otp_pkg::DIV_STAGES];
  logic [otp_pkg::D_W-1:0] den_q [otp_pkg::DIV_STAGES];
  logic [otp_pkg::Q_W-1:0] quo_q [otp_pkg::DIV_STAGES];

  for (genvar k = 0; k < otp_pkg::DIV_STAGES; k++) begin : g_stage
    localparam int B0  = otp_pkg::Q_W - 1 - 2 * k;
    localparam int B1  = B0 - 1;
    localparam int SH0 = (B0 >= 0) ? B0 : 0;
    localparam int SH1 = (B1 >= 0) ? B1 : 0;
    logic [otp_pkg::N_W-1:0] rem_in, rem_mid, rem_out, dsh0, dsh1;
    logic [otp_pkg::D_W-1:0] den_in;
    logic [otp_pkg::Q_W-1:0] quo_in, quo_out;

    always_comb begin
      if (k == 0) begin
        rem_in = num;
        den_in = den;
        quo_in = '0;
      end else begin
        rem_in = rem_q[(k == 0) ? 0 : k - 1];
        den_in = den_q[(k == 0) ? 0 : k - 1];
        quo_in = quo_q[(k == 0) ? 0 : k - 1];
      end
      dsh0 = otp_pkg::N_W'(den_in) << SH0;
      dsh1 = otp_pkg::N_W'(den_in) << SH1;
      rem_mid = rem_in;
      quo_out = quo_in;
      if (B0 >= 0 && rem_in >= dsh0) begin
        rem_mid = rem_in - dsh0;
        quo_out[SH0] = 1'b1;
      end
      rem_out = rem_mid;
      if (B1 >= 0 && rem_mid >= dsh1) begin
        rem_out = rem_mid - dsh1;
        quo_out[SH1] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_out;
        den_q[k] <= den_in;
        quo_q[k] <= quo_out;
      end
    end
  end

  assign quo = quo_q[otp_pkg::DIV_STAGES-1];
endmodule

FILE: rtl/octahedral_tangent_pack_top.sv
// Octahedral tangent packer: one tangent in, one packed 32-bit word out.
// Depends on otp_pkg, otp_divider and octahedral_tangent_pack_top_defines.svh.
//
//   channel  handshake            payload
//   input    in_valid / in_ready  x_component, y_component, z_component, handed_negative
//   output   out_valid / out_ready packed_word
//
// One item per cycle while the output register is empty or taken; the
// divider resolves two quotient bits per stage.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits only; a stalled output holds every stage.
`include "octahedral_tangent_pack_top_defines.svh"
module octahedral_tangent_pack_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] x_component,
  input  logic [15:0] y_component,
  input  logic [15:0] z_component,
  input  logic        handed_negative,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] packed_word
);
  localparam int S_W = otp_pkg::S_W;
  localparam int N_W = otp_pkg::N_W;
  localparam int DS  = otp_pkg::DIV_STAGES;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: magnitudes, L1 norm, lower-half fold
  logic signed [otp_pkg::IN_WIDTH-1:0] xs, ys, zs;
  logic [S_W-1:0] ax, ay, az, s_sum;
  logic           s1_valid;
  logic [S_W-1:0] s1_s, s1_mag_u, s1_mag_v;
  otp_pkg::side_t s1_side;

  always_comb begin
    xs = x_component[otp_pkg::IN_WIDTH-1:0];
    ys = y_component[otp_pkg::IN_WIDTH-1:0];
    zs = z_component[otp_pkg::IN_WIDTH-1:0];
    ax = xs[otp_pkg::IN_WIDTH-1] ? S_W'(-S_W'(xs)) : S_W'(xs);
    ay = ys[otp_pkg::IN_WIDTH-1] ? S_W'(-S_W'(ys)) : S_W'(ys);
    az = zs[otp_pkg::IN_WIDTH-1] ? S_W'(-S_W'(zs)) : S_W'(zs);
    s_sum = ax + ay + az;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_s           <= s_sum;
      s1_mag_u       <= zs[otp_pkg::IN_WIDTH-1] ? s_sum - ay : ax;
      s1_mag_v       <= zs[otp_pkg::IN_WIDTH-1] ? s_sum - ax : ay;
      s1_side.neg_u  <= xs[otp_pkg::IN_WIDTH-1];
      s1_side.neg_v  <= ys[otp_pkg::IN_WIDTH-1];
      s1_side.zero   <= (s_sum == '0);
      s1_side.flip   <= handed_negative;
    end
  end

  // stage 2: dividends 2*mag*STEPS + s, divisor 2*s
  logic           s2_valid;
  logic [N_W-1:0] s2_num_u, s2_num_v;
  logic [otp_pkg::D_W-1:0] s2_den;
  otp_pkg::side_t s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_num_u <= ((N_W'(s1_mag_u) * N_W'(otp_pkg::STEPS)) << 1) + N_W'(s1_s);
      s2_num_v <= ((N_W'(s1_mag_v) * N_W'(otp_pkg::STEPS)) << 1) + N_W'(s1_s);
      s2_den   <= {s1_s, 1'b0};
      s2_side  <= s1_side;
    end
  end

  // divider stages
  logic [otp_pkg::Q_W-1:0] q_u, q_v;
  logic                    d_valid [DS];
  otp_pkg::side_t          d_side  [DS];

  otp_divider u_div_u (.clk(clk), .en(en), .num(s2_num_u), .den(s2_den), .quo(q_u));
  otp_divider u_div_v (.clk(clk), .en(en), .num(s2_num_v), .den(s2_den), .quo(q_v));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DS; i++) d_valid[i] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= s2_valid;
      for (int i = 1; i < DS; i++) d_valid[i] <= d_valid[i-1];
    end
    if (en) begin
      d_side[0] <= s2_side;
      for (int i = 1; i < DS; i++) d_side[i] <= d_side[i-1];
    end
  end

  // output stage: offset codes and pack
  otp_pkg::side_t        f_side;
  logic [otp_pkg::CODE_W-1:0] code_u, code_v;
  logic [63:0]           word_wide;

  always_comb begin
    f_side = d_side[DS-1];
    code_u = f_side.neg_u ? otp_pkg::CODE_W'(otp_pkg::STEPS) - otp_pkg::CODE_W'(q_u)
                          : otp_pkg::CODE_W'(otp_pkg::STEPS) + otp_pkg::CODE_W'(q_u);
    code_v = f_side.neg_v ? otp_pkg::CODE_W'(otp_pkg::STEPS) - otp_pkg::CODE_W'(q_v)
                          : otp_pkg::CODE_W'(otp_pkg::STEPS) + otp_pkg::CODE_W'(q_v);
    word_wide = (64'(code_u) & ((64'd1 << otp_pkg::COORD_BITS) - 64'd1))
              | ((64'(code_v) & ((64'd1 << otp_pkg::COORD_BITS) - 64'd1))
                 << otp_pkg::COORD_BITS)
              | (64'd1 << otp_pkg::PRESENT_BIT)
              | (64'(f_side.flip) << otp_pkg::FLIPPED_BIT);
    if (f_side.zero) word_wide = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[DS-1];
    end
    if (en) begin
      packed_word <= word_wide[31:0];
    end
  end

  // a held result blocks the input side
  `OTP_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  // a word without the present flag is the zero-vector word
  `OTP_ASSERT_NOW(a_zero_word, out_valid && !packed_word[otp_pkg::PRESENT_BIT],
                  packed_word == 32'd0)
  // a stall freezes the pipe's front stage
  `OTP_ASSERT_NEXT(a_stall_holds_s1, out_valid && !out_ready,
                   $stable(s1_valid) && $stable(s1_s))
endmodule

FILE: tb/otp_checker.sv
// Checker for the octahedral tangent packer: watches both channels,
// predicts each packed word and compares in order. Depends on otp_pkg.
`timescale 1ns / 1ps
module otp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] x_component,
  input  logic [15:0] y_component,
  input  logic [15:0] z_component,
  input  logic        handed_negative,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] packed_word,
  output int          fail_count,
  output int          words_pending
);
  logic [31:0] word_q[$];

  // round(num*STEPS/s) half away from zero, offset by STEPS
  function automatic longint coord_code(longint num, longint s);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (2 * mag * otp_pkg::STEPS + s) / (2 * s);
    return num < 0 ? otp_pkg::STEPS - q : otp_pkg::STEPS + q;
  endfunction

  function automatic logic [31:0] pack_tangent(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z, logic flip);
    longint ax, ay, az, s, nu, nv, cmask;
    logic [63:0] w;
    ax = x < 0 ? -longint'(x) : longint'(x);
    ay = y < 0 ? -longint'(y) : longint'(y);
    az = z < 0 ? -longint'(z) : longint'(z);
    s = ax + ay + az;
    cmask = (longint'(1) << otp_pkg::COORD_BITS) - 1;
    if (s == 0) return '0;
    if (z < 0) begin
      nu = x >= 0 ? s - ay : ay - s;
      nv = y >= 0 ? s - ax : ax - s;
    end else begin
      nu = x;
      nv = y;
    end
    w = (coord_code(nu, s) & cmask)
      | ((coord_code(nv, s) & cmask) << otp_pkg::COORD_BITS);
    w |= 64'd1 << otp_pkg::PRESENT_BIT;
    if (flip) w |= 64'd1 << otp_pkg::FLIPPED_BIT;
    return w[31:0];
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        word_q.push_back(pack_tangent(x_component, y_component, z_component,
                                      handed_negative));
      if (out_valid && out_ready) begin
        if (word_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", packed_word);
          fail_count <= fail_count + 1;
        end else begin
          want = word_q.pop_front();
          if (want !== packed_word) begin
            if (fail_count < 10)
              $display("packed_word mismatch: expected %h got %h", want, packed_word);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    words_pending <= word_q.size();
  end
endmodule

FILE: tb/tb_top.sv
// Top of the octahedral tangent packer testbench: clock, reset, stimulus
// and verdict. Depends on octahedral_tangent_pack_top and otp_checker.
`timescale 1ns / 1ps
module tb_top;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] x_component;
  logic [15:0] y_component;
  logic [15:0] z_component;
  logic        handed_negative;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] packed_word;
  int          fail_count;
  int          words_pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          cycle_count;

  octahedral_tangent_pack_top i_dut (.*);

  otp_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= $urandom_range(99) >= recv_stall_pct;
  end

  task automatic send_tangent(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic h);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_component <= x;
    y_component <= y;
    z_component <= z;
    handed_negative <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_component();
    case ($urandom_range(5))
      0: return 16'($urandom_range(8)) - 16'd4;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2: return 16'($urandom_range(600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dir_vals[7];
    rst = 1'b1;
    in_valid = 1'b0;
    x_component = '0;
    y_component = '0;
    z_component = '0;
    handed_negative = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    dir_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0003, 16'hfffd};
    // zero vector with either handedness, axes, extremes, folded half
    send_tangent(16'd0, 16'd0, 16'd0, 1'b0);
    send_tangent(16'd0, 16'd0, 16'd0, 1'b1);
    for (int i = 0; i < 21; i++)
      send_tangent(dir_vals[i % 7], dir_vals[(i * 3 + 1) % 7], dir_vals[(i * 5 + 2) % 7], i[0]);
    send_tangent(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_tangent(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b1; end
      endcase
      for (int n = 0; n < 350; n++) begin
        logic [15:0] z;
        z = pick_component();
        // about three in four lie in the folded lower half
        if ($urandom_range(1) && !z[15]) z = -z;
        send_tangent(pick_component(), pick_component(), z, 1'($urandom));
      end
    end
    in_valid <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    int held;
    wait (hold_off);
    held = 0;
    while (held < 200) begin
      @(posedge clk);
      held++;
    end
    hold_off = 1'b0;
  end
endmodule

FILE: octahedral_tangent_pack_top.f
+incdir+rtl
rtl/otp_pkg.sv
rtl/otp_divider.sv
rtl/octahedral_tangent_pack_top.sv
tb/otp_checker.sv
tb/tb_top.sv
